### rtl/packed_symmetric_matvec_unit_assert.svh
// Assertion macros shared by the packed symmetric matvec RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef PACKED_SYMMETRIC_MATVEC_UNIT_ASSERT_SVH
`define PACKED_SYMMETRIC_MATVEC_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define PSMV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PSMV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/psmv_pkg.sv
// Package for the packed symmetric matvec unit: widths, codes, FSM states
// and the saturating add. No dependencies.
package psmv_pkg;

    // Sizes
    localparam int MAX_PAIRS = 1024;
    localparam int PAIR_W    = $clog2(MAX_PAIRS);
    localparam int ROW_W     = PAIR_W + 1;
    localparam int VAL_W     = 64;
    localparam int HALF_W    = VAL_W / 2;
    localparam int PP_W      = 2 * (HALF_W + 1);
    localparam int PROD_W    = 2 * VAL_W;
    localparam int FRAC_W    = 48;
    localparam int FUNC_W    = 2;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_ROW   = 1'b1;

    localparam logic [ROW_W-1:0] END_ROW_RST = ROW_W'(MAX_PAIRS);

    // Saturation limits
    localparam logic [VAL_W-1:0] SMAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] SMIN = {1'b1, {(VAL_W-1){1'b0}}};

    // Multiplier step counter: four partial products, then the done count
    localparam int             MUL_CNT_W    = 3;
    localparam logic [MUL_CNT_W-1:0] MUL_LAST_PP  = 3'd3;
    localparam logic [MUL_CNT_W-1:0] MUL_DONE_CNT = 3'd5;

    // Item function codes
    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD   = 2'd0,
        FN_MATRIX = 2'd1,
        FN_READ   = 2'd2,
        FN_START  = 2'd3
    } t_func;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_MUL_D_RS,
        S_MUL_D_PQ,
        S_WR_RS,
        S_WR_PQ,
        S_READ
    } t_state;

    // Signed add that clamps to the 64-bit limits
    function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W-1:0] s;
        s = a + b;
        if (a[VAL_W-1] == b[VAL_W-1] && s[VAL_W-1] != a[VAL_W-1]) begin
            return a[VAL_W-1] ? SMIN : SMAX;
        end
        return s;
    endfunction

endpackage

### rtl/psmv_in_if.sv
// Input channel of the packed symmetric matvec unit: valid/ready plus item.
// Depends on psmv_pkg.
interface psmv_in_if import psmv_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [FUNC_W-1:0]       func;
    logic [PAIR_W-1:0]       pair_index;
    logic signed [VAL_W-1:0] value;
    logic                    is_diagonal;

    modport source (output valid, func, pair_index, value, is_diagonal, input ready);
    modport sink   (input valid, func, pair_index, value, is_diagonal, output ready);
endinterface

### rtl/psmv_out_if.sv
// Result channel of the packed symmetric matvec unit: valid/ready plus item.
// Depends on psmv_pkg.
interface psmv_out_if import psmv_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [PAIR_W-1:0]       result_index;
    logic signed [VAL_W-1:0] result_value;

    modport source (output valid, result_index, result_value, input ready);
    modport sink   (input valid, result_index, result_value, output ready);
endinterface

### rtl/psmv_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module psmv_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re_a,
    input  logic [AW-1:0]    i_raddr_a,
    output logic [WIDTH-1:0] o_rdata_a,
    input  logic             i_re_b,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read ports, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re_a) begin
            o_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

### rtl/psmv_fxmul.sv
// Iterative Q15.48 multiplier: 64x64 product from four 33x33 partial products,
// floor shift by 48 and saturation. Depends on psmv_pkg and the assert header.
`include "packed_symmetric_matvec_unit_assert.svh"

module psmv_fxmul import psmv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [VAL_W-1:0] i_a,
    input  logic [VAL_W-1:0] i_b,
    output logic             o_done,
    output logic [VAL_W-1:0] o_product
);

    logic                 r_busy;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [VAL_W-1:0]     r_a;
    logic [VAL_W-1:0]     r_b;
    logic signed [PP_W-1:0] r_pp;
    logic [1:0]           r_pp_sh;
    logic                 r_pp_vld;
    logic [PROD_W-1:0]    r_acc;

    logic [1:0]              w_sel;
    logic signed [HALF_W:0]  w_op_a;
    logic signed [HALF_W:0]  w_op_b;
    logic signed [PP_W-1:0]  w_pp;
    logic [1:0]              w_sh;
    logic [PROD_W-1:0]       w_pp_ext;
    logic [PROD_W-1:0]       w_pp_shifted;
    logic [PROD_W-VAL_W-FRAC_W:0] w_top;

    // Operand halves: upper half signed, lower half zero-extended
    assign w_sel  = r_cnt[1:0];
    assign w_op_a = w_sel[1] ? {r_a[VAL_W-1], r_a[VAL_W-1:HALF_W]} : {1'b0, r_a[HALF_W-1:0]};
    assign w_op_b = w_sel[0] ? {r_b[VAL_W-1], r_b[VAL_W-1:HALF_W]} : {1'b0, r_b[HALF_W-1:0]};
    assign w_pp   = w_op_a * w_op_b;
    assign w_sh   = {w_sel[1] & w_sel[0], w_sel[1] ^ w_sel[0]};

    // Align the registered partial product
    assign w_pp_ext = {{(PROD_W-PP_W){r_pp[PP_W-1]}}, r_pp};
    always_comb begin
        case (r_pp_sh)
            2'd0:    w_pp_shifted = w_pp_ext;
            2'd1:    w_pp_shifted = w_pp_ext << HALF_W;
            default: w_pp_shifted = w_pp_ext << VAL_W;
        endcase
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_pp_vld <= 1'b0;
        end else if (i_start) begin
            r_busy   <= 1'b1;
            r_cnt    <= '0;
            r_pp_vld <= 1'b0;
        end else if (r_busy) begin
            r_cnt    <= r_cnt + 1'b1;
            r_pp_vld <= (r_cnt <= MUL_LAST_PP);
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Operands, partial product and accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt <= MUL_LAST_PP) begin
                r_pp    <= w_pp;
                r_pp_sh <= w_sh;
            end
            if (r_pp_vld) begin
                r_acc <= r_acc + w_pp_shifted;
            end
        end
    end

    // Floor shift by the fraction width, clamp when the top bits disagree
    assign w_top     = r_acc[PROD_W-1:VAL_W+FRAC_W-1];
    assign o_done    = r_busy && (r_cnt == MUL_DONE_CNT);
    assign o_product = (&w_top || ~|w_top) ? r_acc[VAL_W+FRAC_W-1:FRAC_W]
                     : (r_acc[PROD_W-1] ? SMIN : SMAX);

    `PSMV_ASSERT_IMPL(a_start_when_free, i_clk, i_rst_n, i_start, !r_busy || o_done, "multiplier restarted while busy")
    `PSMV_ASSERT_NEXT(a_done_ends_run, i_clk, i_rst_n, o_done && !i_start, !r_busy && !o_done, "multiplier kept running after done")

endmodule

### rtl/packed_symmetric_matvec_unit.sv
// A matrix element runs two 64x64 products through one 33x33 multiplier, four
// partial products each, plus a second result write when it closes a row.
// A density load or a batch start is done on acceptance; a read holds until
// the output register is free, and that register parts the two sides of the block.
// Reset (synchronous, active low) clears control, then zeroes all 1024 result
// memory entries one entry a cycle with input ready low; density is not cleared.
`include "packed_symmetric_matvec_unit_assert.svh"

module packed_symmetric_matvec_unit import psmv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    psmv_in_if.sink              i_in,
    psmv_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // Registers
    t_state            r_state;
    logic [PAIR_W-1:0] r_first_row;
    logic [ROW_W-1:0]  r_end_row;
    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  r_col;
    logic [VAL_W-1:0]  r_row_acc;
    logic [VAL_W-1:0]  r_val;
    logic [VAL_W-1:0]  r_d_pq;
    logic [VAL_W-1:0]  r_res;
    logic [PAIR_W-1:0] r_rd_idx;
    logic              r_clr_busy;
    logic [PAIR_W-1:0] r_clr_addr;
    logic              r_out_vld;
    logic [PAIR_W-1:0] r_out_idx;
    logic [VAL_W-1:0]  r_out_val;

    t_state            n_state;

    // Combinational controls
    t_func             w_func;
    logic              w_in_ready;
    logic              w_accept;
    logic              w_skip;
    logic              w_row_end;
    logic              w_out_free;
    logic              w_out_load;

    logic              dens_we;
    logic [PAIR_W-1:0] dens_waddr;
    logic [VAL_W-1:0]  dens_wdata;
    logic              dens_re;
    logic [VAL_W-1:0]  dens_rd_rs;
    logic [VAL_W-1:0]  dens_rd_pq;

    logic              res_we;
    logic [PAIR_W-1:0] res_waddr;
    logic [VAL_W-1:0]  res_wdata;
    logic              res_re;
    logic [PAIR_W-1:0] res_raddr;
    logic [VAL_W-1:0]  res_rdata;

    logic              mul_start;
    logic [VAL_W-1:0]  mul_b;
    logic              mul_done;
    logic [VAL_W-1:0]  mul_prod;

    assign w_func     = t_func'(i_in.func);
    assign w_accept   = i_in.valid && w_in_ready;
    assign w_skip     = (r_row >= r_end_row) || (r_row >= ROW_W'(MAX_PAIRS))
                     || (r_col >= ROW_W'(MAX_PAIRS));
    assign w_row_end  = (r_col >= r_row);
    assign w_out_free = !r_out_vld || o_out.ready;

    // Density memory: one write, reads of D[rs] and D[pq]
    psmv_ram #(.WIDTH(VAL_W), .DEPTH(MAX_PAIRS)) u_dens_ram (
        .i_clk     (i_clk),
        .i_we      (dens_we),
        .i_waddr   (dens_waddr),
        .i_wdata   (dens_wdata),
        .i_re_a    (dens_re),
        .i_raddr_a (r_col[PAIR_W-1:0]),
        .o_rdata_a (dens_rd_rs),
        .i_re_b    (dens_re),
        .i_raddr_b (r_row[PAIR_W-1:0]),
        .o_rdata_b (dens_rd_pq)
    );

    // Result memory: read-modify-write through one read port
    psmv_ram #(.WIDTH(VAL_W), .DEPTH(MAX_PAIRS)) u_res_ram (
        .i_clk     (i_clk),
        .i_we      (res_we),
        .i_waddr   (res_waddr),
        .i_wdata   (res_wdata),
        .i_re_a    (res_re),
        .i_raddr_a (res_raddr),
        .o_rdata_a (res_rdata),
        .i_re_b    (1'b0),
        .i_raddr_b ('0),
        .o_rdata_b ()
    );

    // Shared product unit, first operand is always the matrix element
    psmv_fxmul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (r_val),
        .i_b       (mul_b),
        .o_done    (mul_done),
        .o_product (mul_prod)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_func == FN_MATRIX && !w_skip) begin
                        n_state = S_FETCH;
                    end else if (w_func == FN_READ) begin
                        n_state = S_READ;
                    end
                end
            end
            S_FETCH:    n_state = S_MUL_D_RS;
            S_MUL_D_RS: if (mul_done) n_state = S_MUL_D_PQ;
            S_MUL_D_PQ: if (mul_done) n_state = S_WR_RS;
            S_WR_RS:    n_state = w_row_end ? S_WR_PQ : S_IDLE;
            S_WR_PQ:    n_state = S_IDLE;
            S_READ:     if (w_out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Memory, multiplier and handshake controls
    always_comb begin
        w_in_ready = (r_state == S_IDLE) && !r_clr_busy;
        w_out_load = 1'b0;
        dens_we    = 1'b0;
        dens_waddr = i_in.pair_index;
        dens_wdata = i_in.is_diagonal ? i_in.value : sat_add(i_in.value, i_in.value);
        dens_re    = 1'b0;
        res_re     = 1'b0;
        res_raddr  = r_col[PAIR_W-1:0];
        res_we     = 1'b0;
        res_waddr  = r_col[PAIR_W-1:0];
        res_wdata  = r_res;
        mul_start  = 1'b0;
        mul_b      = dens_rd_rs;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_func)
                        FN_LOAD:   dens_we = 1'b1;
                        FN_MATRIX: begin
                            dens_re = !w_skip;
                            res_re  = !w_skip;
                        end
                        FN_READ: begin
                            res_re    = 1'b1;
                            res_raddr = i_in.pair_index;
                        end
                        default: ;
                    endcase
                end
            end
            S_FETCH: mul_start = 1'b1;
            S_MUL_D_RS: begin
                mul_start = mul_done;
                mul_b     = r_d_pq;
            end
            S_WR_RS: res_we = 1'b1;
            S_WR_PQ: begin
                res_we    = 1'b1;
                res_waddr = r_row[PAIR_W-1:0];
            end
            S_READ: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    res_we     = 1'b1;
                    res_waddr  = r_rd_idx;
                    res_wdata  = '0;
                end
            end
            default: ;
        endcase
        // Clearing sweep after reset; no item is in flight then
        if (r_clr_busy) begin
            res_we    = 1'b1;
            res_waddr = r_clr_addr;
            res_wdata = '0;
        end
    end

    // Control state, counters and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first_row <= '0;
            r_end_row   <= END_ROW_RST;
            r_row       <= '0;
            r_col       <= '0;
            r_row_acc   <= '0;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FIRST_ROW: r_first_row <= i_cfg_data[PAIR_W-1:0];
                    CFG_END_ROW:   r_end_row   <= i_cfg_data[ROW_W-1:0];
                    default: ;
                endcase
            end

            if (w_accept && w_func == FN_START) begin
                r_row     <= {1'b0, r_first_row};
                r_col     <= '0;
                r_row_acc <= '0;
            end

            case (r_state)
                S_MUL_D_RS: if (mul_done) r_row_acc <= sat_add(r_row_acc, mul_prod);
                S_WR_RS:    if (!w_row_end) r_col <= r_col + 1'b1;
                S_WR_PQ: begin
                    r_row_acc <= '0;
                    r_row     <= r_row + 1'b1;
                    r_col     <= '0;
                end
                default: ;
            endcase

            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == PAIR_W'(MAX_PAIRS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_val    <= i_in.value;
            r_rd_idx <= i_in.pair_index;
        end
        case (r_state)
            S_FETCH: begin
                r_d_pq <= dens_rd_pq;
                r_res  <= res_rdata;
            end
            S_MUL_D_PQ: if (mul_done) r_res <= sat_add(r_res, mul_prod);
            S_WR_RS:    if (w_row_end) r_res <= sat_add(r_res, r_row_acc);
            default: ;
        endcase
        if (w_out_load) begin
            r_out_idx <= r_rd_idx;
            r_out_val <= res_rdata;
        end
    end

    // Ports
    assign i_in.ready         = w_in_ready;
    assign o_out.valid        = r_out_vld;
    assign o_out.result_index = r_out_idx;
    assign o_out.result_value = r_out_val;

    `PSMV_ASSERT_IMPL(a_col_within_row, i_clk, i_rst_n, r_state == S_IDLE, r_col <= r_row, "column counter passed the row counter")
    `PSMV_ASSERT_IMPL(a_mul_done_in_mul_state, i_clk, i_rst_n, mul_done, (r_state == S_MUL_D_RS) || (r_state == S_MUL_D_PQ), "product finished outside a multiply state")
    `PSMV_ASSERT_NEXT(a_read_waits_for_output, i_clk, i_rst_n, (r_state == S_READ) && r_out_vld && !o_out.ready, r_state == S_READ, "read left while output register was full")

endmodule
